[hw/rtl/mcr_pkg.sv]
package mcr_pkg;

    typedef struct packed {
        logic        func;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [10:0] radius;
        logic        fill_mode;
        logic        pen_color;
    } cmd_t;

    typedef struct packed {
        logic        write_enable;
        logic [16:0] byte_addr;
        logic [7:0]  pixel_mask;
        logic        bit_value;
        logic        last_of_step;
        logic        circle_done;
    } pix_t;

    // one queued step: either a done word or eight symmetric pixels
    typedef struct packed {
        logic        done;
        logic [15:0] cx;
        logic [15:0] cy;
        logic [11:0] a;
        logic [11:0] b;
        logic        color;
    } job_t;

    typedef struct packed {
        logic [1:0]  rotation_mode;
        logic [10:0] screen_width;
        logic [10:0] screen_height;
    } cfg_t;

    typedef struct packed {
        logic swap;
        logic neg_x;
        logic neg_y;
    } pix_sel_t;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam logic [1:0] REG_ROTATION = 2'd0;
    localparam logic [1:0] REG_WIDTH    = 2'd1;
    localparam logic [1:0] REG_HEIGHT   = 2'd2;

    localparam logic [10:0] WIDTH_RESET  = 11'd200;
    localparam logic [10:0] HEIGHT_RESET = 11'd200;

    // octant order of the eight symmetric pixels
    function automatic pix_sel_t pixel_sel(input logic [2:0] k);
        pix_sel_t s;
        case (k)
            3'd0: s = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b0};
            3'd1: s = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b0};
            3'd2: s = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b0};
            3'd3: s = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b1};
            3'd4: s = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b1};
            3'd5: s = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b1};
            3'd6: s = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b1};
            default: s = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b0};
        endcase
        return s;
    endfunction

endpackage

[hw/rtl/midpoint_circle_rasterizer.sv]
// Midpoint circle rasterizer for a 1-bit framebuffer. A start word (func 0) latches center,
// radius, fill mode and pen color and produces no output. Each step word (func 1) yields eight
// pixel words, one per cycle while pix_stall is low; a step while no circle is active yields a
// single circle_done word. The back end issues one pixel per cycle, unless the output stalls,
// into a three-register pipeline (coordinate add, rotation and bounds check, byte address
// multiply). The front end updates the midpoint state in the cycle it takes a word and parks up
// to four steps in a queue, so commands keep flowing while pixels stall until the queue fills.
// Pixels outside the screen come out with write_enable low and zero payload. The user must
// write screen size and rotation over the register port only while the block is idle; the
// block itself does not enforce this.
module midpoint_circle_rasterizer #(
    parameter int MAX_DIM = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  mcr_pkg::cmd_t cmd,
    output logic          pix_valid,
    input  logic          pix_stall,
    output mcr_pkg::pix_t pix,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import mcr_pkg::*;

    logic [1:0]  rotation_reg;
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic        cfg_write;
    cfg_t        cfg;

    logic        job_push;
    job_t        push_job;
    logic        job_pop;
    job_t        head;
    logic        job_full;
    logic        job_empty;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_reg <= ROT_0;
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_ROTATION: rotation_reg <= pwdata[1:0];
                REG_WIDTH:    width_reg    <= pwdata[10:0];
                REG_HEIGHT:   height_reg   <= pwdata[10:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ROTATION: prdata = {30'd0, rotation_reg};
            REG_WIDTH:    prdata = {21'd0, width_reg};
            REG_HEIGHT:   prdata = {21'd0, height_reg};
            default:      prdata = 32'd0;
        endcase
    end

    assign cfg = '{rotation_mode: rotation_reg, screen_width: width_reg,
                   screen_height: height_reg};

    mcr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .job_push  (job_push),
        .job       (push_job),
        .job_full  (job_full)
    );

    mcr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .pop      (job_pop),
        .head     (head),
        .full     (job_full),
        .empty    (job_empty)
    );

    mcr_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job       (head),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix)
    );

endmodule

[hw/rtl/mcr_front.sv]
module mcr_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  mcr_pkg::cmd_t cmd,
    output logic          job_push,
    output mcr_pkg::job_t job,
    input  logic          job_full
);
    import mcr_pkg::*;

    logic [15:0] center_x_reg, center_x_next;
    logic [15:0] center_y_reg, center_y_next;
    logic [11:0] minor_reg, minor_next;
    logic [11:0] major_reg, major_next;
    logic [11:0] span_reg, span_next;
    logic [15:0] decision_reg, decision_next;
    logic        active_reg, active_next;
    logic        fill_reg, fill_next;
    logic        color_reg, color_next;

    logic        accept;
    logic        d_pos;
    logic [13:0] x_inc;
    logic [13:0] y_adv;
    logic        active_adv;
    logic [15:0] x4;
    logic [15:0] y4;
    logic [15:0] d_adv;

    assign cmd_stall = job_full;
    assign accept    = cmd_valid && !job_full;
    assign job_push  = accept && (cmd.func == FUNC_STEP);

    always_comb
    begin
        job.done  = !active_reg;
        job.cx    = center_x_reg;
        job.cy    = center_y_reg;
        job.a     = minor_reg;
        job.b     = fill_reg ? span_reg : major_reg;
        job.color = color_reg;
    end

    // midpoint advance
    assign d_pos      = !decision_reg[15];
    assign x_inc      = {2'b00, minor_reg} + 14'd1;
    assign y_adv      = {2'b00, major_reg} - {13'd0, d_pos};
    assign active_adv = $signed(x_inc) <= $signed(y_adv);
    assign x4         = {2'b00, minor_reg, 2'b00};
    assign y4         = {2'b00, major_reg, 2'b00};
    assign d_adv      = d_pos ? (decision_reg + 16'd10 + x4 - y4) : (decision_reg + x4 + 16'd6);

    always_comb
    begin
        center_x_next = center_x_reg;
        center_y_next = center_y_reg;
        minor_next    = minor_reg;
        major_next    = major_reg;
        span_next     = span_reg;
        decision_next = decision_reg;
        active_next   = active_reg;
        fill_next     = fill_reg;
        color_next    = color_reg;
        if (accept)
        begin
            unique case (cmd.func)
                FUNC_START:
                begin
                    center_x_next = cmd.center_x;
                    center_y_next = cmd.center_y;
                    fill_next     = cmd.fill_mode;
                    color_next    = cmd.pen_color;
                    minor_next    = 12'd0;
                    major_next    = {1'b0, cmd.radius};
                    span_next     = 12'd0;
                    decision_next = 16'd3 - {4'd0, cmd.radius, 1'b0};
                    active_next   = 1'b1;
                end
                FUNC_STEP:
                begin
                    if (active_reg)
                    begin
                        if (fill_reg && (span_reg < major_reg))
                        begin
                            span_next = span_reg + 12'd1;
                        end
                        else
                        begin
                            minor_next    = x_inc[11:0];
                            major_next    = y_adv[11:0];
                            span_next     = x_inc[11:0];
                            decision_next = d_adv;
                            active_next   = active_adv;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            minor_reg    <= '0;
            major_reg    <= '0;
            span_reg     <= '0;
            decision_reg <= '0;
            active_reg   <= 1'b0;
            fill_reg     <= 1'b0;
            color_reg    <= 1'b0;
        end
        else
        begin
            center_x_reg <= center_x_next;
            center_y_reg <= center_y_next;
            minor_reg    <= minor_next;
            major_reg    <= major_next;
            span_reg     <= span_next;
            decision_reg <= decision_next;
            active_reg   <= active_next;
            fill_reg     <= fill_next;
            color_reg    <= color_next;
        end
    end

endmodule

[hw/rtl/mcr_queue.sv]
module mcr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mcr_pkg::job_t push_job,
    input  logic          pop,
    output mcr_pkg::job_t head,
    output logic          full,
    output logic          empty
);
    import mcr_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    job_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = count_reg == (AW+1)'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hw/rtl/mcr_back.sv]
module mcr_back #(
    parameter int MAX_DIM = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  mcr_pkg::cfg_t cfg,
    input  mcr_pkg::job_t job,
    input  logic          job_empty,
    output logic          job_pop,
    output logic          pix_valid,
    input  logic          pix_stall,
    output mcr_pkg::pix_t pix
);
    import mcr_pkg::*;

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int YW = $clog2(MAX_DIM);
    localparam int BW = $clog2((MAX_DIM + 7) / 8 + 1);
    localparam int SW = YW + BW + 1;

    // framebuffer geometry, registered copies of the config register values
    logic [1:0]    rot_reg;
    logic [DW-1:0] w_reg;
    logic [DW-1:0] h_reg;
    logic [15:0]   wm1_reg;
    logic [15:0]   hm1_reg;
    logic [BW-1:0] bpr_reg;
    logic [DW-1:0] w_sat;
    logic [DW-1:0] h_sat;
    logic [DW:0]   w_round;

    logic [2:0]  k_reg, k_next;
    logic        issue;
    logic        adv_out;
    logic        adv_s2;
    logic        adv_s1;

    pix_sel_t    sel;
    logic [15:0] u;
    logic [15:0] v;
    logic [15:0] px;
    logic [15:0] py;

    logic        s1_valid_reg;
    logic [15:0] s1_px_reg;
    logic [15:0] s1_py_reg;
    logic        s1_done_reg;
    logic        s1_last_reg;
    logic        s1_color_reg;

    logic [15:0] rx;
    logic [15:0] ry;
    logic        s2_valid_reg;
    logic [15:0] s2_cx_reg;
    logic [15:0] s2_cy_reg;
    logic        s2_inside_reg;
    logic        s2_done_reg;
    logic        s2_last_reg;
    logic        s2_color_reg;

    logic [YW+BW-1:0] prod;
    logic [SW-1:0]    addr_sum;
    logic             pix_valid_reg;
    pix_t             pix_reg;
    pix_t             pix_next;

    assign w_sat   = (32'(cfg.screen_width) > MAX_DIM) ? DW'(MAX_DIM) : DW'(cfg.screen_width);
    assign h_sat   = (32'(cfg.screen_height) > MAX_DIM) ? DW'(MAX_DIM) : DW'(cfg.screen_height);
    assign w_round = {1'b0, w_sat} + (DW+1)'(7);

    always_ff @(posedge clk)
    begin
        rot_reg <= cfg.rotation_mode;
        w_reg   <= w_sat;
        h_reg   <= h_sat;
        wm1_reg <= 16'(w_sat) - 16'd1;
        hm1_reg <= 16'(h_sat) - 16'd1;
        bpr_reg <= BW'(w_round >> 3);
    end

    assign adv_out = !pix_valid_reg || !pix_stall;
    assign adv_s2  = !s2_valid_reg || adv_out;
    assign adv_s1  = !s1_valid_reg || adv_s2;
    assign issue   = !job_empty && adv_s1;
    assign job_pop = issue && (job.done || (k_reg == 3'd7));

    always_comb
    begin
        k_next = k_reg;
        if (issue)
        begin
            k_next = job_pop ? 3'd0 : k_reg + 3'd1;
        end
    end

    // pixel k of the head step
    always_comb
    begin
        sel = pixel_sel(k_reg);
        u   = {4'd0, sel.swap ? job.b : job.a};
        v   = {4'd0, sel.swap ? job.a : job.b};
        px  = sel.neg_x ? job.cx - u : job.cx + u;
        py  = sel.neg_y ? job.cy - v : job.cy + v;
    end

    // rotation
    always_comb
    begin
        unique case (rot_reg)
            ROT_0:
            begin
                rx = s1_py_reg;
                ry = s1_px_reg;
            end
            ROT_90:
            begin
                rx = s1_px_reg;
                ry = hm1_reg - s1_py_reg;
            end
            ROT_180:
            begin
                rx = wm1_reg - s1_py_reg;
                ry = hm1_reg - s1_px_reg;
            end
            ROT_270:
            begin
                rx = wm1_reg - s1_px_reg;
                ry = s1_py_reg;
            end
        endcase
    end

    // byte address and mask
    assign prod     = s2_cy_reg[YW-1:0] * bpr_reg;
    assign addr_sum = {1'b0, prod} + SW'(s2_cx_reg[BW+2:3]);

    always_comb
    begin
        pix_next              = '0;
        pix_next.last_of_step = s2_last_reg;
        if (s2_done_reg)
        begin
            pix_next.circle_done = 1'b1;
        end
        else if (s2_inside_reg)
        begin
            pix_next.write_enable = 1'b1;
            pix_next.byte_addr    = 17'(addr_sum);
            pix_next.pixel_mask   = 8'h80 >> s2_cx_reg[2:0];
            pix_next.bit_value    = s2_color_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= 3'd0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg <= k_next;
            if (adv_s1)
            begin
                s1_valid_reg <= issue;
            end
            if (adv_s2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv_out)
            begin
                pix_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_s1)
        begin
            s1_px_reg    <= px;
            s1_py_reg    <= py;
            s1_done_reg  <= job.done;
            s1_last_reg  <= job.done || (k_reg == 3'd7);
            s1_color_reg <= job.color;
        end
        if (adv_s2)
        begin
            s2_cx_reg     <= rx;
            s2_cy_reg     <= ry;
            s2_inside_reg <= (rx < 16'(w_reg)) && (ry < 16'(h_reg));
            s2_done_reg   <= s1_done_reg;
            s2_last_reg   <= s1_last_reg;
            s2_color_reg  <= s1_color_reg;
        end
        if (adv_out)
        begin
            pix_reg <= pix_next;
        end
    end

    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

endmodule
